>>> src/mst_pkg.sv
// Package for the message slot table: command codes, sequencer states and
// fixed field widths. No dependencies.
package mst_pkg;

  localparam int CMD_W  = 3;   // command field
  localparam int SLOT_W = 4;   // slot field and slot-valued results
  localparam int TEXT_W = 16;  // handle field on the ports
  localparam int EXT_W  = 32;  // widest stored handle

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_DEL_ALL = 3'd3,
    CMD_MARK    = 3'd4,
    CMD_COMPACT = 3'd5,
    CMD_READ    = 3'd6
  } cmd_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_EXEC  = 10'b0000000010,
    S_ADD   = 10'b0000000100,
    S_CLR   = 10'b0000001000,
    S_CTEST = 10'b0000010000,
    S_CMOVE = 10'b0000100000,
    S_CZERO = 10'b0001000000,
    S_RWAIT = 10'b0010000000,
    S_SUM   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

endpackage

>>> src/mst_handle_store.sv
// Handle storage of the message slot table: one write port, one registered
// read port. No dependencies.
module mst_handle_store #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/message_slot_table_core.sv
// Message slot table top level: command sequencer, slot flags, status scan
// and output register. Uses mst_pkg and mst_handle_store.
//
// Usage
//   One command per input transfer (cmd, slot, text_handle, emergency) on the
//   in_valid / in_stall channel; one result per command on out_valid /
//   out_stall. A transfer happens on a rising edge with valid high and stall
//   low. in_stall is high while a command is being worked on.
//   Every command runs through a small sequencer: S_IDLE takes the command,
//   S_EXEC issues it, then comes the command's own walk over the slots
//   (S_ADD, S_CLR, or S_CTEST / S_CMOVE / S_CZERO; read slot waits in S_RWAIT
//   for the registered RAM read), then a status walk (S_SUM) over up to
//   SLOT_COUNT slots, and S_DONE loads the output register.
//   The handle RAM has one write port, so compaction moves each entry by a
//   read, a write to the left slot and a zeroing of the right slot, and
//   delete all writes one slot at a time.
//   Reset is synchronous: all slots empty, unread, non-emergency; no result
//   pending. Handles are not reset; delete and delete all write zero.
//   The output register holds a finished result while out_stall is high; the
//   next command is taken meanwhile and waits at its last cycle until the
//   output register is free.
module message_slot_table_core #(
  parameter int SLOT_COUNT  = 8,
  parameter int HANDLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mst_pkg::CMD_W-1:0]  cmd,
  input  logic [mst_pkg::SLOT_W-1:0] slot,
  input  logic [mst_pkg::TEXT_W-1:0] text_handle,
  input  logic                       emergency,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mst_pkg::TEXT_W-1:0] entry_handle,
  output logic                       entry_emergency,
  output logic                       entry_empty,
  output logic                       entry_read,
  output logic                       slot_error,
  output logic [mst_pkg::SLOT_W-1:0] written_slot,
  output logic                       any_unread,
  output logic                       emergency_found,
  output logic [mst_pkg::SLOT_W-1:0] emergency_slot
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST   = IDX_W'(SLOT_COUNT - 1);
  localparam logic [IDX_W-1:0] PENULT = IDX_W'(SLOT_COUNT - 2);
  localparam logic [mst_pkg::SLOT_W:0] SLOT_LIMIT = (mst_pkg::SLOT_W + 1)'(SLOT_COUNT);

  mst_pkg::state_t state;
  mst_pkg::cmd_t   cmd_q;

  // latched command
  logic [IDX_W-1:0]       s_q;
  logic                   rng_q;
  logic [HANDLE_BITS-1:0] wr_val;
  logic                   emer_q;

  // slot index walker
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_nx;

  // slot flags
  logic [SLOT_COUNT-1:0] emer_f;
  logic [SLOT_COUNT-1:0] empty_f;
  logic [SLOT_COUNT-1:0] read_f;

  // result being built
  logic [mst_pkg::TEXT_W-1:0] r_handle;
  logic                       r_emer, r_empty, r_read, r_err;
  logic [mst_pkg::SLOT_W-1:0] r_written;
  logic                       r_any, r_found;
  logic [mst_pkg::SLOT_W-1:0] r_eslot;

  // handle RAM port
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [HANDLE_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]       mem_raddr;
  logic [HANDLE_BITS-1:0] mem_rdata;
  logic [mst_pkg::EXT_W-1:0] rd_ext;
  logic [mst_pkg::EXT_W-1:0] wr_ext;

  logic in_xfer;
  logic out_free;

  assign in_stall = (state != mst_pkg::S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign idx_nx   = idx + 1'b1;
  assign rd_ext   = mst_pkg::EXT_W'(mem_rdata);

  mst_handle_store #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (HANDLE_BITS),
    .AW    (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // RAM control follows the sequencer state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '0;
    mem_raddr = idx_nx;
    case (state)
      mst_pkg::S_EXEC: begin
        if (cmd_q == mst_pkg::CMD_WRITE && rng_q) begin
          mem_we    = 1'b1;
          mem_waddr = s_q;
          mem_wdata = wr_val;
        end else if (cmd_q == mst_pkg::CMD_DELETE && rng_q) begin
          mem_we    = 1'b1;
          mem_waddr = s_q;
        end
        if (cmd_q == mst_pkg::CMD_READ) begin
          mem_raddr = s_q;
        end
      end
      mst_pkg::S_ADD: begin
        if (empty_f[idx] || idx == LAST) begin
          mem_we    = 1'b1;
          mem_wdata = wr_val;
        end
      end
      mst_pkg::S_CLR: begin
        mem_we = 1'b1;
      end
      mst_pkg::S_CMOVE: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      mst_pkg::S_CZERO: begin
        mem_we    = 1'b1;
        mem_waddr = idx_nx;
      end
      default: begin
      end
    endcase
  end

  // command payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_q  <= mst_pkg::cmd_t'(cmd);
      s_q    <= slot[IDX_W-1:0];
      rng_q  <= ({1'b0, slot} < SLOT_LIMIT);
      wr_val <= wr_ext[HANDLE_BITS-1:0];
      emer_q <= emergency;
    end
  end

  assign wr_ext = mst_pkg::EXT_W'(text_handle);

  // sequencer, flags and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mst_pkg::S_IDLE;
      idx       <= '0;
      emer_f    <= '0;
      empty_f   <= '1;
      read_f    <= '0;
      out_valid <= 1'b0;
    end else begin
      // a result handed over in S_DONE sets out_valid below instead
      if (out_valid && !out_stall && state != mst_pkg::S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        mst_pkg::S_IDLE: begin
          if (in_xfer) begin
            r_handle  <= '0;
            r_emer    <= 1'b0;
            r_empty   <= 1'b0;
            r_read    <= 1'b0;
            r_err     <= 1'b0;
            r_written <= '0;
            r_any     <= 1'b0;
            r_found   <= 1'b0;
            r_eslot   <= '0;
            idx       <= '0;
            state     <= mst_pkg::S_EXEC;
          end
        end
        mst_pkg::S_EXEC: begin
          state <= mst_pkg::S_SUM;
          case (cmd_q)
            mst_pkg::CMD_WRITE: begin
              if (rng_q) begin
                emer_f[s_q]  <= emer_q;
                empty_f[s_q] <= 1'b0;
              end else begin
                r_err <= 1'b1;
              end
            end
            mst_pkg::CMD_ADD: state <= mst_pkg::S_ADD;
            mst_pkg::CMD_DELETE: begin
              if (rng_q) begin
                emer_f[s_q]  <= 1'b0;
                empty_f[s_q] <= 1'b1;
                read_f[s_q]  <= 1'b0;
              end else begin
                r_err <= 1'b1;
              end
            end
            mst_pkg::CMD_DEL_ALL: begin
              emer_f  <= '0;
              empty_f <= '1;
              read_f  <= '0;
              state   <= mst_pkg::S_CLR;
            end
            mst_pkg::CMD_MARK: begin
              if (rng_q) begin
                read_f[s_q] <= 1'b1;
              end else begin
                r_err <= 1'b1;
              end
            end
            mst_pkg::CMD_COMPACT: state <= mst_pkg::S_CTEST;
            mst_pkg::CMD_READ: begin
              if (rng_q) begin
                state <= mst_pkg::S_RWAIT;
              end else begin
                r_err <= 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        mst_pkg::S_ADD: begin
          // first empty slot, or the last slot when the table is full
          if (empty_f[idx] || idx == LAST) begin
            if (!empty_f[idx]) begin
              read_f[idx] <= 1'b0;
            end
            emer_f[idx]  <= emer_q;
            empty_f[idx] <= 1'b0;
            r_written    <= mst_pkg::SLOT_W'(idx);
            idx          <= '0;
            state        <= mst_pkg::S_SUM;
          end else begin
            idx <= idx_nx;
          end
        end
        mst_pkg::S_CLR: begin
          if (idx == LAST) begin
            idx   <= '0;
            state <= mst_pkg::S_SUM;
          end else begin
            idx <= idx_nx;
          end
        end
        mst_pkg::S_CTEST: begin
          if (!empty_f[idx]) begin
            if (idx == PENULT) begin
              idx   <= '0;
              state <= mst_pkg::S_SUM;
            end else begin
              idx <= idx_nx;
            end
          end else if (empty_f[idx_nx]) begin
            // two holes in a row end the pass
            idx   <= '0;
            state <= mst_pkg::S_SUM;
          end else begin
            state <= mst_pkg::S_CMOVE;
          end
        end
        mst_pkg::S_CMOVE: begin
          emer_f[idx]     <= emer_f[idx_nx];
          empty_f[idx]    <= 1'b0;
          read_f[idx]     <= read_f[idx_nx];
          emer_f[idx_nx]  <= 1'b0;
          empty_f[idx_nx] <= 1'b1;
          read_f[idx_nx]  <= 1'b0;
          state           <= mst_pkg::S_CZERO;
        end
        mst_pkg::S_CZERO: begin
          if (idx == PENULT) begin
            idx   <= '0;
            state <= mst_pkg::S_SUM;
          end else begin
            idx   <= idx_nx;
            state <= mst_pkg::S_CTEST;
          end
        end
        mst_pkg::S_RWAIT: begin
          r_handle <= rd_ext[mst_pkg::TEXT_W-1:0];
          r_emer   <= emer_f[s_q];
          r_empty  <= empty_f[s_q];
          r_read   <= read_f[s_q];
          state    <= mst_pkg::S_SUM;
        end
        mst_pkg::S_SUM: begin
          // status walk: stops at the first empty slot or first unread emergency
          if (empty_f[idx]) begin
            state <= mst_pkg::S_DONE;
          end else begin
            if (!read_f[idx]) begin
              r_any <= 1'b1;
            end
            if (!read_f[idx] && emer_f[idx]) begin
              r_found <= 1'b1;
              r_eslot <= mst_pkg::SLOT_W'(idx);
              state   <= mst_pkg::S_DONE;
            end else if (idx == LAST) begin
              state <= mst_pkg::S_DONE;
            end else begin
              idx <= idx_nx;
            end
          end
        end
        mst_pkg::S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= mst_pkg::S_IDLE;
          end
        end
        default: state <= mst_pkg::S_IDLE;
      endcase
    end
  end

  // output register, loaded when the result is handed over
  always_ff @(posedge clk) begin
    if (state == mst_pkg::S_DONE && out_free) begin
      entry_handle    <= r_handle;
      entry_emergency <= r_emer;
      entry_empty     <= r_empty;
      entry_read      <= r_read;
      slot_error      <= r_err;
      written_slot    <= r_written;
      any_unread      <= r_any;
      emergency_found <= r_found;
      emergency_slot  <= r_eslot;
    end
  end

endmodule
